[rtl/cab_pkg.sv]
package cab_pkg;

   // coordinate, colour and configuration port widths
   localparam int CoordBits = 16;
   localparam int ColorBits = 8;
   localparam int CsrIdxBits = 4;
   localparam int CsrDataBits = 16;

   localparam logic [ColorBits-1:0] AlphaOpaque = 8'hff;
   localparam logic [ColorBits-1:0] AlphaClear = 8'h00;

   // action codes
   localparam logic ActionFill = 1'b0;
   localparam logic ActionBlit = 1'b1;

   // register indexes of the configuration port
   typedef enum logic [CsrIdxBits-1:0] {
      CSR_CLIP_LEFT   = 4'd0,
      CSR_CLIP_TOP    = 4'd1,
      CSR_CLIP_RIGHT  = 4'd2,
      CSR_CLIP_BOTTOM = 4'd3,
      CSR_DRAW_RED    = 4'd4,
      CSR_DRAW_GREEN  = 4'd5,
      CSR_DRAW_BLUE   = 4'd6,
      CSR_DRAW_ALPHA  = 4'd7
   } csr_index_type;

   // per-pixel control carried down the pipeline
   typedef struct packed {
      logic blit;
      logic write;
      logic opaque;
   } ctl_type;

endpackage

[rtl/cab_channel.sv]
// one colour channel of the blend datapath, two register stages
module cab_channel (
   input  logic                          clock,
   input  logic [cab_pkg::ColorBits-1:0] src_c,
   input  logic [cab_pkg::ColorBits-1:0] dst_c,
   input  logic [cab_pkg::ColorBits-1:0] draw_c,
   input  cab_pkg::ctl_type              ctl_a,
   input  logic [cab_pkg::ColorBits-1:0] alpha_a,
   input  cab_pkg::ctl_type              ctl_b,
   output logic [cab_pkg::ColorBits-1:0] result_c
);

   localparam int CW = cab_pkg::ColorBits;

   logic [2*CW-1:0] tint_ff, tint_in;
   logic [CW-1:0]   dst_a_ff;
   logic [3*CW-1:0] mul_hi_ff, mul_hi_in;
   logic [2*CW-1:0] mul_lo_ff, mul_lo_in;
   logic [CW-1:0]   dst_b_ff;
   logic [CW-1:0]   inv_alpha;
   logic [2*CW-1:0] fill_prod;
   logic [CW:0]     blit_sum;
   logic [2*CW:0]   fill_sum;

   // stage a: tint product
   assign tint_in = src_c * draw_c;

   // stage b: colour term and destination term
   assign inv_alpha = cab_pkg::AlphaOpaque - alpha_a;
   assign fill_prod = draw_c * alpha_a;
   always_comb begin
      if (ctl_a.blit) begin
         mul_hi_in = tint_ff * alpha_a;
      end else begin
         mul_hi_in = {{CW{1'b0}}, fill_prod};
      end
      mul_lo_in = dst_a_ff * inv_alpha;
   end

   always_ff @(posedge clock) begin
      tint_ff   <= tint_in;
      dst_a_ff  <= dst_c;
      mul_hi_ff <= mul_hi_in;
      mul_lo_ff <= mul_lo_in;
      dst_b_ff  <= dst_a_ff;
   end

   // final sum and selection
   assign blit_sum = {1'b0, mul_hi_ff[3*CW-1:2*CW]} + {1'b0, mul_lo_ff[2*CW-1:CW]};
   assign fill_sum = {1'b0, mul_hi_ff[2*CW-1:0]} + {1'b0, mul_lo_ff};

   always_comb begin
      if (!ctl_b.write) begin
         result_c = dst_b_ff;
      end else if (ctl_b.opaque) begin
         result_c = draw_c;
      end else if (ctl_b.blit) begin
         result_c = blit_sum[CW-1:0];
      end else begin
         result_c = fill_sum[2*CW-1:CW];
      end
   end

endmodule

[rtl/clipped_alpha_blend_pixel_core.sv]
// per-pixel fill and tinted blit engine with a clip rectangle. one pixel is
// taken in every clock cycle (busy is never raised) and its result appears
// on the rsp_ ports after the three register stages of the blend, for one
// cycle only, marked by rsp_valid; the receiver cannot stall it, so it must
// take every result. the stages are tint and source alpha product, colour
// and destination products, then the final sum in the output register.
// pixels outside the clip rectangle or drawn with a zero draw alpha come
// out with rsp_write_enable low and the destination pixel unchanged.
// configuration registers must only be written while no pixel is in
// flight; csr_ready is always high.
module clipped_alpha_blend_pixel_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // pixel input
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_action,
   input  logic signed [cab_pkg::CoordBits-1:0]   req_pixel_x,
   input  logic signed [cab_pkg::CoordBits-1:0]   req_pixel_y,
   input  logic [cab_pkg::ColorBits-1:0]          req_dst_red,
   input  logic [cab_pkg::ColorBits-1:0]          req_dst_green,
   input  logic [cab_pkg::ColorBits-1:0]          req_dst_blue,
   input  logic [cab_pkg::ColorBits-1:0]          req_dst_alpha,
   input  logic [cab_pkg::ColorBits-1:0]          req_src_red,
   input  logic [cab_pkg::ColorBits-1:0]          req_src_green,
   input  logic [cab_pkg::ColorBits-1:0]          req_src_blue,
   input  logic [cab_pkg::ColorBits-1:0]          req_src_alpha,
   // result output
   output logic                                   rsp_valid,
   output logic                                   rsp_write_enable,
   output logic [cab_pkg::ColorBits-1:0]          rsp_out_red,
   output logic [cab_pkg::ColorBits-1:0]          rsp_out_green,
   output logic [cab_pkg::ColorBits-1:0]          rsp_out_blue,
   output logic [cab_pkg::ColorBits-1:0]          rsp_out_alpha,
   // configuration write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cab_pkg::CsrIdxBits-1:0]         csr_index,
   input  logic [cab_pkg::CsrDataBits-1:0]        csr_wdata
);

   localparam int CW = cab_pkg::ColorBits;
   localparam int XW = cab_pkg::CoordBits;

   // configuration registers
   logic signed [XW-1:0] clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;
   logic [CW-1:0]        draw_red_ff, draw_green_ff, draw_blue_ff, draw_alpha_ff;

   logic                 accept;
   logic                 csr_write;
   logic                 in_clip;
   cab_pkg::ctl_type     ctl_in;
   logic [2*CW-1:0]      src_alpha_prod;
   logic [CW-1:0]        alpha_in;

   // stage a
   logic                 valid_a_ff;
   cab_pkg::ctl_type     ctl_a_ff;
   logic [CW-1:0]        alpha_a_ff;
   logic [CW-1:0]        dst_alpha_a_ff;
   // stage b
   logic                 valid_b_ff;
   cab_pkg::ctl_type     ctl_b_ff;
   logic [CW-1:0]        dst_alpha_b_ff;
   // output register
   logic                 rsp_valid_ff;
   logic                 write_enable_ff;
   logic [CW-1:0]        out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff;
   logic [CW-1:0]        red_c, green_c, blue_c, alpha_c;

   // no back-pressure anywhere, so a pixel is taken every cycle
   assign busy      = 1'b0;
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // configuration register file
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_right_ff  <= '0;
         clip_bottom_ff <= '0;
         draw_red_ff    <= '0;
         draw_green_ff  <= '0;
         draw_blue_ff   <= '0;
         draw_alpha_ff  <= '0;
      end else if (csr_write) begin
         unique case (cab_pkg::csr_index_type'(csr_index))
            cab_pkg::CSR_CLIP_LEFT:   clip_left_ff   <= csr_wdata[XW-1:0];
            cab_pkg::CSR_CLIP_TOP:    clip_top_ff    <= csr_wdata[XW-1:0];
            cab_pkg::CSR_CLIP_RIGHT:  clip_right_ff  <= csr_wdata[XW-1:0];
            cab_pkg::CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata[XW-1:0];
            cab_pkg::CSR_DRAW_RED:    draw_red_ff    <= csr_wdata[CW-1:0];
            cab_pkg::CSR_DRAW_GREEN:  draw_green_ff  <= csr_wdata[CW-1:0];
            cab_pkg::CSR_DRAW_BLUE:   draw_blue_ff   <= csr_wdata[CW-1:0];
            cab_pkg::CSR_DRAW_ALPHA:  draw_alpha_ff  <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // clip test: left and top inclusive, right and bottom exclusive
   assign in_clip = (req_pixel_x >= clip_left_ff) && (req_pixel_x < clip_right_ff) &&
                    (req_pixel_y >= clip_top_ff)  && (req_pixel_y < clip_bottom_ff);

   always_comb begin
      ctl_in.blit   = (req_action == cab_pkg::ActionBlit);
      ctl_in.write  = in_clip && (draw_alpha_ff != cab_pkg::AlphaClear);
      ctl_in.opaque = (req_action == cab_pkg::ActionFill) &&
                      (draw_alpha_ff == cab_pkg::AlphaOpaque);
   end

   // blit scales the source alpha by the draw alpha, fill uses draw alpha
   assign src_alpha_prod = req_src_alpha * draw_alpha_ff;
   assign alpha_in = ctl_in.blit ? src_alpha_prod[2*CW-1:CW] : draw_alpha_ff;

   // control pipeline, valid bits reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= accept;
         valid_b_ff   <= valid_a_ff;
         rsp_valid_ff <= valid_b_ff;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      ctl_a_ff        <= ctl_in;
      alpha_a_ff      <= alpha_in;
      dst_alpha_a_ff  <= req_dst_alpha;
      ctl_b_ff        <= ctl_a_ff;
      dst_alpha_b_ff  <= dst_alpha_a_ff;
      write_enable_ff <= ctl_b_ff.write;
      out_red_ff      <= red_c;
      out_green_ff    <= green_c;
      out_blue_ff     <= blue_c;
      out_alpha_ff    <= alpha_c;
   end

   // alpha: opaque fill gives full alpha, every other case keeps destination
   assign alpha_c = (ctl_b_ff.write && ctl_b_ff.opaque) ? cab_pkg::AlphaOpaque
                                                        : dst_alpha_b_ff;

   cab_channel u_red (
      .clock    (clock),
      .src_c    (req_src_red),
      .dst_c    (req_dst_red),
      .draw_c   (draw_red_ff),
      .ctl_a    (ctl_a_ff),
      .alpha_a  (alpha_a_ff),
      .ctl_b    (ctl_b_ff),
      .result_c (red_c)
   );

   cab_channel u_green (
      .clock    (clock),
      .src_c    (req_src_green),
      .dst_c    (req_dst_green),
      .draw_c   (draw_green_ff),
      .ctl_a    (ctl_a_ff),
      .alpha_a  (alpha_a_ff),
      .ctl_b    (ctl_b_ff),
      .result_c (green_c)
   );

   cab_channel u_blue (
      .clock    (clock),
      .src_c    (req_src_blue),
      .dst_c    (req_dst_blue),
      .draw_c   (draw_blue_ff),
      .ctl_a    (ctl_a_ff),
      .alpha_a  (alpha_a_ff),
      .ctl_b    (ctl_b_ff),
      .result_c (blue_c)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = write_enable_ff;
   assign rsp_out_red      = out_red_ff;
   assign rsp_out_green    = out_green_ff;
   assign rsp_out_blue     = out_blue_ff;
   assign rsp_out_alpha    = out_alpha_ff;

   // every accepted pixel gives its result transfer via valid_a_ff, valid_b_ff, rsp_valid_ff
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("result transfer missing three cycles after accept");

   // a pixel that is not written passes its destination alpha through
   a_keep_alpha : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |-> (rsp_out_alpha == $past(req_dst_alpha, 3)))
      else $error("unwritten pixel changed its alpha");

   // zero draw alpha never writes
   a_clear_no_write : assert property (@(posedge clock) disable iff (reset)
      (accept && draw_alpha_ff == cab_pkg::AlphaClear) |-> ##3 !rsp_write_enable)
      else $error("write with zero draw alpha");

endmodule

[tb/pixel_blend_checker.sv]
`timescale 1ns / 1ps

module pixel_blend_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic                                 req_action,
   input  logic signed [cab_pkg::CoordBits-1:0] req_pixel_x,
   input  logic signed [cab_pkg::CoordBits-1:0] req_pixel_y,
   input  logic [cab_pkg::ColorBits-1:0]        req_dst_red,
   input  logic [cab_pkg::ColorBits-1:0]        req_dst_green,
   input  logic [cab_pkg::ColorBits-1:0]        req_dst_blue,
   input  logic [cab_pkg::ColorBits-1:0]        req_dst_alpha,
   input  logic [cab_pkg::ColorBits-1:0]        req_src_red,
   input  logic [cab_pkg::ColorBits-1:0]        req_src_green,
   input  logic [cab_pkg::ColorBits-1:0]        req_src_blue,
   input  logic [cab_pkg::ColorBits-1:0]        req_src_alpha,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_write_enable,
   input  logic [cab_pkg::ColorBits-1:0]        rsp_out_red,
   input  logic [cab_pkg::ColorBits-1:0]        rsp_out_green,
   input  logic [cab_pkg::ColorBits-1:0]        rsp_out_blue,
   input  logic [cab_pkg::ColorBits-1:0]        rsp_out_alpha,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [cab_pkg::CsrIdxBits-1:0]       csr_index,
   input  logic [cab_pkg::CsrDataBits-1:0]      csr_wdata,
   output int                                   fail_count,
   output int                                   backlog,
   output int                                   pixel_count,
   output int                                   write_count
);

   localparam int CW = cab_pkg::ColorBits;
   localparam int XW = cab_pkg::CoordBits;

   typedef struct packed {
      logic          write_enable;
      logic [CW-1:0] red;
      logic [CW-1:0] green;
      logic [CW-1:0] blue;
      logic [CW-1:0] alpha;
   } pixel_result_type;

   // shadow of the configuration registers
   logic signed [XW-1:0] clip_left, clip_top, clip_right, clip_bottom;
   logic [CW-1:0]        draw_red, draw_green, draw_blue, draw_alpha;

   pixel_result_type expected_pixels [$];
   pixel_result_type want;
   int fails = 0;
   int pixels = 0;
   int writes = 0;

   function automatic logic [CW-1:0] fill_mix(logic [CW-1:0] c, d);
      int unsigned sum;
      sum = int'(c) * int'(draw_alpha) +
            int'(d) * (int'(cab_pkg::AlphaOpaque) - int'(draw_alpha));
      return sum[15:8];
   endfunction

   function automatic logic [CW-1:0] tint_mix(logic [CW-1:0] s, t, d, int unsigned a);
      int unsigned sum;
      sum = ((int'(s) * int'(t) * a) >> 16) +
            ((int'(d) * (int'(cab_pkg::AlphaOpaque) - a)) >> 8);
      return sum[7:0];
   endfunction

   function automatic pixel_result_type blend_pixel();
      pixel_result_type r;
      int unsigned      scaled;
      logic             in_clip;
      r = '{1'b0, req_dst_red, req_dst_green, req_dst_blue, req_dst_alpha};
      in_clip = req_pixel_x >= clip_left && req_pixel_x < clip_right &&
                req_pixel_y >= clip_top && req_pixel_y < clip_bottom;
      if (!in_clip || draw_alpha == cab_pkg::AlphaClear)
         return r;
      r.write_enable = 1'b1;
      if (req_action == cab_pkg::ActionFill) begin
         if (draw_alpha == cab_pkg::AlphaOpaque) begin
            r = '{1'b1, draw_red, draw_green, draw_blue, cab_pkg::AlphaOpaque};
         end else begin
            r.red   = fill_mix(draw_red, req_dst_red);
            r.green = fill_mix(draw_green, req_dst_green);
            r.blue  = fill_mix(draw_blue, req_dst_blue);
         end
      end else begin
         // source alpha scaled by the tint alpha first
         scaled  = (int'(req_src_alpha) * int'(draw_alpha)) >> 8;
         r.red   = tint_mix(req_src_red, draw_red, req_dst_red, scaled);
         r.green = tint_mix(req_src_green, draw_green, req_dst_green, scaled);
         r.blue  = tint_mix(req_src_blue, draw_blue, req_dst_blue, scaled);
      end
      return r;
   endfunction

   task automatic check_field(string name, int unsigned expected_val, int unsigned actual_val);
      if (expected_val != actual_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, expected_val, actual_val);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clip_left = '0;
         clip_top = '0;
         clip_right = '0;
         clip_bottom = '0;
         draw_red = '0;
         draw_green = '0;
         draw_blue = '0;
         draw_alpha = '0;
         expected_pixels.delete();
         backlog <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cab_pkg::CSR_CLIP_LEFT:   clip_left   = csr_wdata[XW-1:0];
               cab_pkg::CSR_CLIP_TOP:    clip_top    = csr_wdata[XW-1:0];
               cab_pkg::CSR_CLIP_RIGHT:  clip_right  = csr_wdata[XW-1:0];
               cab_pkg::CSR_CLIP_BOTTOM: clip_bottom = csr_wdata[XW-1:0];
               cab_pkg::CSR_DRAW_RED:    draw_red    = csr_wdata[CW-1:0];
               cab_pkg::CSR_DRAW_GREEN:  draw_green  = csr_wdata[CW-1:0];
               cab_pkg::CSR_DRAW_BLUE:   draw_blue   = csr_wdata[CW-1:0];
               cab_pkg::CSR_DRAW_ALPHA:  draw_alpha  = csr_wdata[CW-1:0];
               default: ;
            endcase
         end
         if (start && !busy)
            expected_pixels.push_back(blend_pixel());
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $error("result transfer with no pixel outstanding");
               fails++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("write_enable", want.write_enable, rsp_write_enable);
               check_field("out_red", want.red, rsp_out_red);
               check_field("out_green", want.green, rsp_out_green);
               check_field("out_blue", want.blue, rsp_out_blue);
               check_field("out_alpha", want.alpha, rsp_out_alpha);
               pixels++;
               if (want.write_enable)
                  writes++;
            end
         end
         backlog <= expected_pixels.size();
      end
      fail_count  <= fails;
      pixel_count <= pixels;
      write_count <= writes;
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int XW = cab_pkg::CoordBits;
   localparam int CW = cab_pkg::ColorBits;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_action;
   logic signed [XW-1:0]        req_pixel_x;
   logic signed [XW-1:0]        req_pixel_y;
   logic [CW-1:0]               req_dst_red, req_dst_green, req_dst_blue, req_dst_alpha;
   logic [CW-1:0]               req_src_red, req_src_green, req_src_blue, req_src_alpha;
   logic                        rsp_valid;
   logic                        rsp_write_enable;
   logic [CW-1:0]               rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [cab_pkg::CsrIdxBits-1:0]  csr_index;
   logic [cab_pkg::CsrDataBits-1:0] csr_wdata;

   // figures handed back by the checker
   int fail_count, backlog, pixel_count, write_count;
   int settings_applied = 0;

   clipped_alpha_blend_pixel_core dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_action(req_action), .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .req_dst_red(req_dst_red), .req_dst_green(req_dst_green),
      .req_dst_blue(req_dst_blue), .req_dst_alpha(req_dst_alpha),
      .req_src_red(req_src_red), .req_src_green(req_src_green),
      .req_src_blue(req_src_blue), .req_src_alpha(req_src_alpha),
      .rsp_valid(rsp_valid), .rsp_write_enable(rsp_write_enable),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_out_alpha(rsp_out_alpha),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pixel_blend_checker u_checker (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_action(req_action), .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .req_dst_red(req_dst_red), .req_dst_green(req_dst_green),
      .req_dst_blue(req_dst_blue), .req_dst_alpha(req_dst_alpha),
      .req_src_red(req_src_red), .req_src_green(req_src_green),
      .req_src_blue(req_src_blue), .req_src_alpha(req_src_alpha),
      .rsp_valid(rsp_valid), .rsp_write_enable(rsp_write_enable),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_out_alpha(rsp_out_alpha),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .backlog(backlog),
      .pixel_count(pixel_count), .write_count(write_count)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // watchdog: the slowest legal run is well under a millisecond
   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // one pixel transfer; start is left high so back-to-back pixels need no gap
   task automatic send_pixel(input logic act, input logic signed [XW-1:0] x, y,
                             input logic [31:0] dst, src);
      start <= 1'b1;
      req_action <= act;
      req_pixel_x <= x;
      req_pixel_y <= y;
      {req_dst_red, req_dst_green, req_dst_blue, req_dst_alpha} <= dst;
      {req_src_red, req_src_green, req_src_blue, req_src_alpha} <= src;
      do @(posedge clock); while (busy);
   endtask

   // sender gap, with rubbish on the pixel fields to show they are ignored
   task automatic pause(input int cycles);
      start <= 1'b0;
      req_pixel_x <= 16'($urandom);
      {req_dst_red, req_dst_green, req_dst_blue, req_dst_alpha} <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every pixel in flight has come back, then let the
   // three-stage pipe settle a little longer
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // writes all eight registers back to back; colour registers get junk in
   // the upper byte, which must be dropped
   task automatic apply_setting(input logic signed [XW-1:0] l, t, r, b,
                                input logic [CW-1:0] red, green, blue, alpha);
      cab_pkg::csr_index_type          order [8];
      logic [cab_pkg::CsrDataBits-1:0] value [8];
      order = '{cab_pkg::CSR_CLIP_LEFT, cab_pkg::CSR_CLIP_TOP,
                cab_pkg::CSR_CLIP_RIGHT, cab_pkg::CSR_CLIP_BOTTOM,
                cab_pkg::CSR_DRAW_RED, cab_pkg::CSR_DRAW_GREEN,
                cab_pkg::CSR_DRAW_BLUE, cab_pkg::CSR_DRAW_ALPHA};
      value = '{l, t, r, b, {8'($urandom), red}, {8'($urandom), green},
                {8'($urandom), blue}, {8'($urandom), alpha}};
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= value[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // mostly near the origin so clip edges get hit, sometimes anywhere
   function automatic logic signed [XW-1:0] pick_coord(input bit wide);
      if (wide)
         return 16'($urandom);
      return 16'($urandom_range(0, 160) - 80);
   endfunction

   function automatic logic [CW-1:0] pick_colour();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // rgba word, with an occasional all-black or all-white pixel
   function automatic logic [31:0] pick_rgba();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
      return $urandom;
   endfunction

   task automatic random_setting();
      logic signed [XW-1:0] l, t, r, b;
      logic [CW-1:0]        alpha;
      case ($urandom_range(0, 5))
         0: begin
            // whole coordinate space less the last column and row
            l = 16'sh8000; t = 16'sh8000; r = 16'sh7fff; b = 16'sh7fff;
         end
         1: begin
            // inverted horizontally
            l = pick_coord(0); r = l - 16'($urandom_range(1, 40));
            t = pick_coord(0); b = t + 16'($urandom_range(1, 40));
         end
         2: begin
            // zero width
            l = pick_coord(0); r = l;
            t = pick_coord(0); b = t + 16'($urandom_range(1, 40));
         end
         3: begin
            l = 16'($urandom); t = 16'($urandom); r = 16'($urandom); b = 16'($urandom);
         end
         default: begin
            l = pick_coord(0); r = l + 16'($urandom_range(1, 60));
            t = pick_coord(0); b = t + 16'($urandom_range(1, 60));
         end
      endcase
      case ($urandom_range(0, 7))
         0: alpha = cab_pkg::AlphaClear;
         1: alpha = cab_pkg::AlphaOpaque;
         2: alpha = 8'h01;
         3: alpha = 8'h80;
         4: alpha = 8'hfe;
         default: alpha = 8'($urandom);
      endcase
      apply_setting(l, t, r, b, pick_colour(), pick_colour(), pick_colour(), alpha);
   endtask

   task automatic random_pixel();
      bit wide;
      wide = ($urandom_range(0, 4) == 0);
      send_pixel($urandom_range(0, 1) ? cab_pkg::ActionBlit : cab_pkg::ActionFill,
                 pick_coord(wide), pick_coord(wide), pick_rgba(), pick_rgba());
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_action <= cab_pkg::ActionFill;
      req_pixel_x <= '0;
      req_pixel_y <= '0;
      {req_dst_red, req_dst_green, req_dst_blue, req_dst_alpha} <= '0;
      {req_src_red, req_src_green, req_src_blue, req_src_alpha} <= '0;
      csr_valid <= 1'b0;
      csr_index <= cab_pkg::CSR_CLIP_LEFT;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // straight out of reset: empty clip and clear draw alpha, nothing written
      send_pixel(cab_pkg::ActionFill, 16'sd0, 16'sd0, 32'h11223344, 32'h55667788);
      send_pixel(cab_pkg::ActionBlit, 16'sd0, 16'sd0, 32'h00000000, 32'hffffffff);
      drain();

      // full-range clip, opaque fill colour
      apply_setting(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                    8'hff, 8'h00, 8'h80, cab_pkg::AlphaOpaque);
      send_pixel(cab_pkg::ActionFill, 16'sh8000, 16'sh8000, 32'h00000000, 32'h00000000);
      // right and bottom bounds are exclusive
      send_pixel(cab_pkg::ActionFill, 16'sh7fff, 16'sh7ffe, 32'hffffffff, 32'h00000000);
      send_pixel(cab_pkg::ActionFill, 16'sh7ffe, 16'sh7fff, 32'h5a5a5a5a, 32'h00000000);
      send_pixel(cab_pkg::ActionFill, 16'sh7ffe, 16'sh7ffe, 32'h12345678, 32'hffffffff);
      // blits: opaque white source, fully transparent source, all white
      send_pixel(cab_pkg::ActionBlit, 16'sd5, -16'sd5, 32'h00000000, 32'hffffffff);
      send_pixel(cab_pkg::ActionBlit, 16'sd5, 16'sd5, 32'hffffffff, 32'hffffff00);
      send_pixel(cab_pkg::ActionBlit, -16'sd1, 16'sd0, 32'hffffffff, 32'hffffffff);
      drain();

      // small clip with a half alpha: walk every edge from both sides
      apply_setting(16'sd10, 16'sd20, 16'sd30, 16'sd40, 8'h40, 8'hc0, 8'hff, 8'h80);
      send_pixel(cab_pkg::ActionFill, 16'sd9, 16'sd20, 32'h80808080, 32'h00000000);
      send_pixel(cab_pkg::ActionFill, 16'sd10, 16'sd20, 32'h80808080, 32'h00000000);
      send_pixel(cab_pkg::ActionFill, 16'sd29, 16'sd39, 32'hffffffff, 32'h00000000);
      send_pixel(cab_pkg::ActionFill, 16'sd30, 16'sd39, 32'hffffffff, 32'h00000000);
      send_pixel(cab_pkg::ActionFill, 16'sd10, 16'sd19, 32'h00000000, 32'h00000000);
      send_pixel(cab_pkg::ActionFill, 16'sd10, 16'sd40, 32'h00000000, 32'h00000000);
      send_pixel(cab_pkg::ActionBlit, 16'sd15, 16'sd25, 32'hffffffff, 32'hffffffff);
      send_pixel(cab_pkg::ActionBlit, 16'sd29, 16'sd20, 32'h00000000, 32'h00ff7f80);
      drain();

      // inverted clip: nothing may be written even with a non-zero alpha
      apply_setting(16'sd50, 16'sd0, 16'sd20, 16'sd100, 8'hff, 8'hff, 8'hff, 8'h01);
      send_pixel(cab_pkg::ActionFill, 16'sd30, 16'sd50, 32'h0f0f0f0f, 32'hf0f0f0f0);
      send_pixel(cab_pkg::ActionBlit, 16'sd30, 16'sd50, 32'h0f0f0f0f, 32'hf0f0f0f0);
      drain();

      // clear draw alpha turns writes off inside a full clip
      apply_setting(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                    8'hff, 8'hff, 8'hff, cab_pkg::AlphaClear);
      send_pixel(cab_pkg::ActionFill, 16'sd0, 16'sd0, 32'h01020304, 32'hffffffff);

      // random phases, each under a fresh register setting; the last two
      // phases run flat out with no sender gaps
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         random_setting();
         for (int n = 0; n < 100; n++) begin
            // once mid-phase, let the pipe run completely dry
            if (phase == 2 && n == 50)
               drain();
            random_pixel();
            if (phase < 6 && $urandom_range(0, 5) == 0)
               pause($urandom_range(1, 18));
         end
      end

      drain();
      $display("summary: %0d pixels checked under %0d register settings, %0d of them written",
               pixel_count, settings_applied, write_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[files.f]
rtl/cab_pkg.sv
rtl/cab_channel.sv
rtl/clipped_alpha_blend_pixel_core.sv
tb/pixel_blend_checker.sv
tb/tb.sv
